// ===== src/mktd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mktd_pkg
// Shared types, codes and the character lookup for the key timing decoder.
// ----------------------------------------------------------------------------
package mktd_pkg;

	localparam logic [1:0] KEY_PRESS   = 2'd1;
	localparam logic [1:0] KEY_RELEASE = 2'd2;

	localparam logic [1:0] KIND_CHAR  = 2'd0;
	localparam logic [1:0] KIND_SPACE = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	localparam logic [1:0] ERR_LONG     = 2'd0;
	localparam logic [1:0] ERR_OVERFLOW = 2'd1;
	localparam logic [1:0] ERR_UNKNOWN  = 2'd2;

	localparam logic [6:0]  SPACE_CHAR    = 7'd32;
	localparam logic [15:0] UNIT_MS_RESET = 16'd130;
	localparam logic [7:0]  DASH_FIRST    = 8'h80;

	localparam int RES_DEPTH = 4;
	localparam int RES_PTR_W = 2;
	localparam int RES_LVL_W = 3;

	localparam int MORSE_ENTRIES = 36;

	localparam logic [7:0] MORSE_CODE [MORSE_ENTRIES] = '{
		8'h42, 8'h84, 8'hA4, 8'h83, 8'h01, 8'h24, 8'hC3, 8'h04, 8'h02,
		8'h74, 8'hA3, 8'h44, 8'hC2, 8'h82, 8'hE3, 8'h64, 8'hD4, 8'h43,
		8'h03, 8'h81, 8'h23, 8'h14, 8'h63, 8'h94, 8'hB4, 8'hC4, 8'hFD,
		8'h7D, 8'h3D, 8'h1D, 8'h0D, 8'h05, 8'h85, 8'hC5, 8'hE5, 8'hF5
	};

	localparam logic [6:0] MORSE_ASCII [MORSE_ENTRIES] = '{
		7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48, 7'h49,
		7'h4A, 7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h4F, 7'h50, 7'h51, 7'h52,
		7'h53, 7'h54, 7'h55, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5A, 7'h30,
		7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39
	};

	typedef enum logic [2:0] {
		PH_IDLE   = 3'b001,
		PH_SYMBOL = 3'b010,
		PH_GAP    = 3'b100
	} phase_t;

	typedef struct packed {
		logic [1:0]  key_state;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [6:0] char_code;
		logic [1:0] error_code;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [1:0] cnt;
		out_item_t  first;
		out_item_t  second;
	} res_push_t;

	function automatic logic [6:0] mktd_lookup(input logic [7:0] code);
		logic [6:0] res;
		res = '0;
		for (int i = 0; i < MORSE_ENTRIES; i++) begin
			if (MORSE_CODE[i] == code) begin
				res = MORSE_ASCII[i];
			end
		end
		return res;
	endfunction

	function automatic out_item_t mktd_item(input logic [1:0] kind, input logic [6:0] ch,
			input logic [1:0] err, input logic last);
		out_item_t it;
		it.kind       = kind;
		it.char_code  = ch;
		it.error_code = err;
		it.last       = last;
		return it;
	endfunction

endpackage

// ===== src/mktd_fsm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mktd_fsm
// Phase machine, press/gap timing and symbol packing; one poll per step.
// ----------------------------------------------------------------------------
module mktd_fsm #(
	parameter int MAX_SYMBOLS = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  mktd_pkg::in_item_t   item,
	input  logic [15:0]          unit_ms,
	output mktd_pkg::res_push_t  push
);
	import mktd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [31:0] start_q, start_d;
	logic        armed_q, armed_d;
	logic [7:0]  pat_q, pat_d;
	logic [2:0]  cnt_q, cnt_d;

	logic [19:0] u3, u7, u10;
	logic [31:0] dur, dur_gap;
	logic [7:0]  code;
	logic [6:0]  ch;
	res_push_t   res;

	assign u3   = 20'({unit_ms, 1'b0}) + 20'(unit_ms);
	assign u7   = 20'({unit_ms, 2'b00}) + u3;
	assign u10  = u7 + u3;
	assign dur  = item.now_ms - start_q;
	assign dur_gap = armed_q ? '0 : dur;
	assign code = pat_q | {5'b0, cnt_q};
	assign ch   = mktd_lookup(code);

	always_comb begin
		phase_d = phase_q;
		start_d = start_q;
		armed_d = armed_q;
		pat_d   = pat_q;
		cnt_d   = cnt_q;
		res     = '0;
		case (phase_q)
			PH_IDLE: begin
				if (item.key_state == KEY_PRESS) begin
					phase_d = PH_SYMBOL;
				end
			end
			PH_SYMBOL: begin
				if (item.key_state == KEY_PRESS) begin
					if (armed_q) begin
						armed_d = 1'b0;
						start_d = item.now_ms;
					end
				end else if (item.key_state == KEY_RELEASE) begin
					armed_d = 1'b1;
					if (dur > 32'(u7)) begin
						res.cnt   = 2'd1;
						res.first = mktd_item(KIND_ERROR, '0, ERR_LONG, 1'b1);
						phase_d = PH_IDLE;
						pat_d   = '0;
						cnt_d   = '0;
					end else if (cnt_q >= 3'(MAX_SYMBOLS)) begin
						res.cnt   = 2'd1;
						res.first = mktd_item(KIND_ERROR, '0, ERR_OVERFLOW, 1'b1);
						phase_d = PH_IDLE;
						pat_d   = '0;
						cnt_d   = '0;
					end else begin
						if (dur >= 32'(u3)) begin
							pat_d = pat_q | (DASH_FIRST >> cnt_q);
						end
						cnt_d   = cnt_q + 3'd1;
						phase_d = PH_GAP;
					end
				end
			end
			PH_GAP: begin
				if (item.key_state == KEY_PRESS) begin
					armed_d = 1'b1;
					if (dur < 32'(u3)) begin
						phase_d = PH_SYMBOL;
					end else begin
						pat_d = '0;
						cnt_d = '0;
						if (ch == '0) begin
							res.cnt   = 2'd1;
							res.first = mktd_item(KIND_ERROR, '0, ERR_UNKNOWN, 1'b1);
							phase_d = PH_IDLE;
						end else begin
							phase_d = PH_SYMBOL;
							if (dur >= 32'(u7)) begin
								res.cnt    = 2'd2;
								res.first  = mktd_item(KIND_CHAR, ch, ERR_LONG, 1'b0);
								res.second = mktd_item(KIND_SPACE, SPACE_CHAR, ERR_LONG, 1'b1);
							end else begin
								res.cnt   = 2'd1;
								res.first = mktd_item(KIND_CHAR, ch, ERR_LONG, 1'b1);
							end
						end
					end
				end else if (item.key_state == KEY_RELEASE) begin
					if (armed_q) begin
						armed_d = 1'b0;
						start_d = item.now_ms;
					end
					if (dur_gap > 32'(u10)) begin
						armed_d = 1'b1;
						pat_d   = '0;
						cnt_d   = '0;
						phase_d = PH_IDLE;
						if (ch == '0) begin
							res.cnt   = 2'd1;
							res.first = mktd_item(KIND_ERROR, '0, ERR_UNKNOWN, 1'b1);
						end else begin
							res.cnt    = 2'd2;
							res.first  = mktd_item(KIND_CHAR, ch, ERR_LONG, 1'b0);
							res.second = mktd_item(KIND_END, '0, ERR_LONG, 1'b1);
						end
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
				pat_d   = '0;
				cnt_d   = '0;
			end
		endcase
	end

	always_comb begin
		push = res;
		if (!step) begin
			push.cnt = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			start_q <= '0;
			armed_q <= 1'b1;
			pat_q   <= '0;
			cnt_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			start_q <= start_d;
			armed_q <= armed_d;
			pat_q   <= pat_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// ===== src/mktd_res_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mktd_res_fifo
// Four-entry result queue; takes up to two results per cycle, gives one.
// ----------------------------------------------------------------------------
module mktd_res_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  mktd_pkg::res_push_t push,
	output logic [2:0]          level,
	output logic                out_valid,
	input  logic                out_ready,
	output mktd_pkg::out_item_t out_data
);
	import mktd_pkg::*;

	out_item_t              mem [RES_DEPTH];
	logic [RES_PTR_W-1:0]   wr_q, rd_q;
	logic [RES_LVL_W-1:0]   level_q;
	logic                   pop;

	assign out_valid = level_q != '0;
	assign out_data  = mem[rd_q];
	assign pop       = out_valid && out_ready;
	assign level     = level_q;

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem[wr_q] <= push.first;
		end
		if (push.cnt == 2'd2) begin
			mem[wr_q + RES_PTR_W'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			wr_q    <= wr_q + RES_PTR_W'(push.cnt);
			rd_q    <= rd_q + RES_PTR_W'(pop);
			level_q <= level_q + RES_LVL_W'(push.cnt) - RES_LVL_W'(pop);
		end
	end

endmodule

// ===== src/morse_key_timing_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_key_timing_decoder
// Times key presses and gaps, packs dots and dashes and emits characters,
// word spaces, end of message and errors.
//
//   channel | signals                        | transaction
//   --------+--------------------------------+------------------------------
//   in      | in_valid / in_ready / in_data  | one key poll with timestamp
//   out     | out_valid / out_ready/out_data | one result, last marks final
//   cfg     | cfg_we / cfg_wdata             | unit length write, no wait
//
// one poll per cycle while the queue has room: a poll sits in the input
// register, is decoded there, and its results land in a four-entry queue
// the input register advances only while the queue has room for two results
// an output stall holds back polls once the queue holds more than two results
// reset clears phase, timing latch and queue; unit length returns to 130
// ----------------------------------------------------------------------------
module morse_key_timing_decoder #(
	parameter int MAX_SYMBOLS = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mktd_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output mktd_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata
);
	import mktd_pkg::*;

	logic        valid_s1;
	in_item_t    data_s1;
	logic [15:0] unit_q;
	logic        step;
	logic [2:0]  level;
	res_push_t   push;

	assign step     = valid_s1 && (level <= 3'd2);
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q <= UNIT_MS_RESET;
		end else if (cfg_we) begin
			unit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

	mktd_fsm #(
		.MAX_SYMBOLS(MAX_SYMBOLS)
	) u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.item    (data_s1),
		.unit_ms (unit_q),
		.push    (push)
	);

	mktd_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.level     (level),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// queue never overfills
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= 3'd4)
		else $error("result queue overflow");

	// the partner of a non-final result is already queued
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last |=> out_valid)
		else $error("second result of a pair missing");

	// error code only on errors
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.kind != KIND_ERROR |-> out_data.error_code == ERR_LONG)
		else $error("error code on a non-error result");

	// results are pushed only on a step, with room for two in the queue
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt != 2'd0 |-> step && level <= 3'd2)
		else $error("results pushed without room");

endmodule

// ===== tb/sv/morse_key_timing_decoder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_key_timing_decoder_test
// Self-checking bench for the key timing decoder. Timed key polls built from
// Morse characters, spoiled characters, broken sequences and noise are sent
// under random flow control on both channels, across several unit lengths.
// Every result is compared field by field with an untimed model of the
// decoder that runs on each accepted poll.
// ----------------------------------------------------------------------------
module morse_key_timing_decoder_test;
	import mktd_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD      = 400;
	localparam int SETTLE_CYCLES  = 6;
	localparam int DRAIN_CYCLES   = 12;
	localparam int SYM_MAX        = 6;
	localparam int PHASES         = 8;
	localparam int PHASE_POLLS    = 210;

	localparam logic [1:0] KEY_NONE  = 2'd0;
	localparam logic [1:0] KEY_SPARE = 2'd3;

	localparam int GAP_SYMBOL = 0;
	localparam int GAP_CHAR   = 1;
	localparam int GAP_WORD   = 2;

	localparam logic [7:0] CHAR_CODES [36] = '{
		8'h42, 8'h84, 8'hA4, 8'h83, 8'h01, 8'h24, 8'hC3, 8'h04, 8'h02,
		8'h74, 8'hA3, 8'h44, 8'hC2, 8'h82, 8'hE3, 8'h64, 8'hD4, 8'h43,
		8'h03, 8'h81, 8'h23, 8'h14, 8'h63, 8'h94, 8'hB4, 8'hC4, 8'hFD,
		8'h7D, 8'h3D, 8'h1D, 8'h0D, 8'h05, 8'h85, 8'hC5, 8'hE5, 8'hF5
	};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	in_item_t    in_data   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        cfg_we    = 1'b0;
	logic [15:0] cfg_wdata = '0;

	morse_key_timing_decoder #(
		.MAX_SYMBOLS(SYM_MAX)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// decoder state as the model sees it
	phase_t      key_phase  = PH_IDLE;
	logic [31:0] mark_ms    = '0;
	logic        mark_armed = 1'b1;
	logic [7:0]  dash_bits  = '0;
	logic [2:0]  sym_count  = '0;
	logic [15:0] unit_len   = UNIT_MS_RESET;

	out_item_t expected_results [$];
	in_item_t  pending_polls [$];

	logic [31:0] stamp_ms = '0;
	logic [31:0] gap_ms   = '0;

	int n_queued    = 0;
	int n_accepted  = 0;
	int n_results   = 0;
	int n_fail      = 0;
	int n_units     = 0;
	int n_kind [4]  = '{0, 0, 0, 0};
	int n_err [4]   = '{0, 0, 0, 0};
	int src_idle    = 0;
	int sink_idle   = 0;
	int src_wait    = 0;
	int sink_wait   = 0;
	int hold_req    = 0;
	int hold_seen   = 0;
	int stall_count = 0;
	logic in_took   = 1'b0;
	out_item_t want;

	function automatic logic [6:0] glyph_of(input logic [7:0] code);
		logic [6:0] g;
		g = '0;
		for (int i = 0; i < 36; i++) begin
			if (CHAR_CODES[i] == code) begin
				g = 7'(i < 26 ? 65 + i : 22 + i);
			end
		end
		return g;
	endfunction

	function automatic logic [6:0] close_char();
		logic [7:0] code;
		code = dash_bits | {5'd0, sym_count};
		dash_bits = '0;
		sym_count = '0;
		return glyph_of(code);
	endfunction

	function automatic out_item_t make_result(input logic [1:0] kind, input logic [6:0] ch,
			input logic [1:0] err);
		out_item_t r;
		r.kind       = kind;
		r.char_code  = ch;
		r.error_code = err;
		r.last       = 1'b0;
		return r;
	endfunction

	task automatic go_idle();
		key_phase = PH_IDLE;
		dash_bits = '0;
		sym_count = '0;
	endtask

	task automatic decode_poll(input in_item_t poll);
		logic [31:0] u3, u7, u10, span_ms;
		logic [6:0]  glyph;
		out_item_t   res [$];
		u3  = 32'd3 * unit_len;
		u7  = 32'd7 * unit_len;
		u10 = 32'd10 * unit_len;
		case (key_phase)
		PH_IDLE: begin
			if (poll.key_state == KEY_PRESS) key_phase = PH_SYMBOL;
		end
		PH_SYMBOL: begin
			if (poll.key_state == KEY_PRESS) begin
				if (mark_armed) begin
					mark_armed = 1'b0;
					mark_ms = poll.now_ms;
				end
			end else if (poll.key_state == KEY_RELEASE) begin
				span_ms = poll.now_ms - mark_ms;
				mark_armed = 1'b1;
				if (span_ms > u7) begin
					res.push_back(make_result(KIND_ERROR, 7'd0, ERR_LONG));
					go_idle();
				end else if (sym_count >= SYM_MAX) begin
					res.push_back(make_result(KIND_ERROR, 7'd0, ERR_OVERFLOW));
					go_idle();
				end else begin
					if (span_ms >= u3) dash_bits = dash_bits | (DASH_FIRST >> sym_count);
					sym_count = sym_count + 3'd1;
					key_phase = PH_GAP;
				end
			end
		end
		PH_GAP: begin
			if (poll.key_state == KEY_PRESS) begin
				span_ms = poll.now_ms - mark_ms;
				mark_armed = 1'b1;
				if (span_ms < u3) begin
					key_phase = PH_SYMBOL;
				end else begin
					glyph = close_char();
					if (glyph == 7'd0) begin
						res.push_back(make_result(KIND_ERROR, 7'd0, ERR_UNKNOWN));
						go_idle();
					end else begin
						res.push_back(make_result(KIND_CHAR, glyph, ERR_LONG));
						if (span_ms >= u7) res.push_back(make_result(KIND_SPACE, SPACE_CHAR, ERR_LONG));
						key_phase = PH_SYMBOL;
					end
				end
			end else if (poll.key_state == KEY_RELEASE) begin
				if (mark_armed) begin
					mark_armed = 1'b0;
					mark_ms = poll.now_ms;
				end
				span_ms = poll.now_ms - mark_ms;
				if (span_ms > u10) begin
					mark_armed = 1'b1;
					glyph = close_char();
					if (glyph == 7'd0) begin
						res.push_back(make_result(KIND_ERROR, 7'd0, ERR_UNKNOWN));
					end else begin
						res.push_back(make_result(KIND_CHAR, glyph, ERR_LONG));
						res.push_back(make_result(KIND_END, 7'd0, ERR_LONG));
					end
					go_idle();
				end
			end
		end
		default: go_idle();
		endcase
		if (res.size() != 0) res[res.size() - 1].last = 1'b1;
		foreach (res[i]) expected_results.push_back(res[i]);
	endtask

	// stimulus building
	function automatic logic [31:0] pick(input logic [31:0] lo, input logic [31:0] hi);
		if (hi <= lo) return lo;
		case ($urandom_range(3, 0))
		0: return lo;
		1: return hi;
		default: return $urandom_range(hi, lo);
		endcase
	endfunction

	function automatic logic [31:0] press_len(input bit dash, input bit spoil);
		logic [31:0] u3, u7;
		u3 = 32'd3 * unit_len;
		u7 = 32'd7 * unit_len;
		if (spoil) return pick(u7 + 32'd1, u7 + u3 + 32'd1);
		if (dash) return pick(u3, u7);
		return (u3 == 0) ? 32'd0 : pick(32'd0, u3 - 32'd1);
	endfunction

	function automatic logic [31:0] gap_len(input int span_kind);
		logic [31:0] u3, u7;
		u3 = 32'd3 * unit_len;
		u7 = 32'd7 * unit_len;
		case (span_kind)
		GAP_SYMBOL: return (u3 == 0) ? 32'd0 : pick(32'd0, u3 - 32'd1);
		GAP_CHAR:   return (u7 == 0) ? 32'd0 : pick(u3, u7 - 32'd1);
		default:    return pick(u7, u7 + u3);
		endcase
	endfunction

	task automatic push_poll(input logic [1:0] key, input logic [31:0] stamp);
		in_item_t p;
		p.key_state = key;
		p.now_ms    = stamp;
		pending_polls.push_back(p);
		n_queued++;
	endtask

	task automatic maybe_noise();
		if ($urandom_range(9, 0) == 0) push_poll($urandom_range(1, 0) ? KEY_SPARE : KEY_NONE, $urandom);
	endtask

	task automatic key_symbol(input logic [31:0] held);
		stamp_ms = stamp_ms + $urandom_range(5, 0);
		push_poll(KEY_PRESS, stamp_ms);
		push_poll(KEY_PRESS, stamp_ms);
		maybe_noise();
		stamp_ms = stamp_ms + held;
		push_poll(KEY_RELEASE, stamp_ms);
		// gap timing starts on the next release poll
		stamp_ms = stamp_ms + $urandom_range(3, 0);
		push_poll(KEY_RELEASE, stamp_ms);
		gap_ms = stamp_ms;
	endtask

	task automatic key_gap(input logic [31:0] spacing);
		stamp_ms = gap_ms + spacing;
		push_poll(KEY_PRESS, stamp_ms);
	endtask

	task automatic key_end(input logic [31:0] after);
		stamp_ms = gap_ms + after;
		push_poll(KEY_RELEASE, stamp_ms);
	endtask

	task automatic key_char(input logic [7:0] code, input int n_sym, input bit spoil);
		for (int k = 0; k < n_sym; k++) begin
			if (k > 0) key_gap(gap_len(GAP_SYMBOL));
			key_symbol(press_len(code[7 - k], spoil && k == n_sym - 1));
		end
	endtask

	task automatic key_message();
		int n_chars;
		int roll;
		logic [7:0] code;
		logic [31:0] u10;
		n_chars = $urandom_range(6, 1);
		u10 = 32'd10 * unit_len;
		for (int c = 0; c < n_chars; c++) begin
			if (c > 0) key_gap(gap_len($urandom_range(3, 0) == 0 ? GAP_WORD : GAP_CHAR));
			roll = $urandom_range(19, 0);
			if (roll < 16) begin
				code = CHAR_CODES[$urandom_range(35, 0)];
				key_char(code, int'(code[2:0]), 1'b0);
			end else if (roll < 19) begin
				key_char(8'($urandom), $urandom_range(7, 1), 1'b0);
			end else begin
				key_char(8'($urandom), $urandom_range(6, 1), 1'b1);
			end
		end
		if ($urandom_range(2, 0) == 0) push_poll(KEY_RELEASE, gap_ms + pick(32'd0, u10));
		key_end(pick(u10 + 32'd1, u10 + u10 / 4 + 32'd1));
	endtask

	task automatic key_junk();
		repeat ($urandom_range(8, 3)) begin
			push_poll(2'($urandom_range(3, 0)), stamp_ms + $urandom_range(32'd12 * unit_len, 0));
		end
	endtask

	task automatic wait_settled();
		while (n_accepted != n_queued || expected_results.size() != 0) @(negedge clk);
		// a poll that yields nothing may still sit in the input register
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_unit(input logic [15:0] value);
		wait_settled();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		unit_len  = value;
		n_units++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// driver
	always @(posedge clk) begin
		in_took = arst_n && in_valid && in_ready;
		if (in_took) begin
			decode_poll(in_data);
			n_accepted++;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_took)) begin
			if (src_wait > 0) begin
				src_wait--;
				in_valid <= 1'b0;
			end else if (src_idle != 0 && $urandom_range(src_idle - 1, 0) == 0) begin
				src_wait = $urandom_range(15, 1) - 1;
				in_valid <= 1'b0;
			end else if (pending_polls.size() != 0) begin
				in_data  <= pending_polls.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (expected_results.size() == 0) begin
				n_fail++;
				$display("%0t: unexpected transaction, expected none, got kind %0d char %0d err %0d last %0d",
					$time, out_data.kind, out_data.char_code, out_data.error_code, out_data.last);
			end else begin
				want = expected_results.pop_front();
				if (out_data.kind !== want.kind || out_data.char_code !== want.char_code ||
						out_data.error_code !== want.error_code || out_data.last !== want.last) begin
					n_fail++;
					$display("%0t: mismatch, expected kind %0d char %0d err %0d last %0d, got kind %0d char %0d err %0d last %0d",
						$time, want.kind, want.char_code, want.error_code, want.last,
						out_data.kind, out_data.char_code, out_data.error_code, out_data.last);
				end
			end
			n_kind[out_data.kind]++;
			if (out_data.kind == KIND_ERROR) n_err[out_data.error_code]++;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				sink_wait = LONG_HOLD;
			end
			if (sink_wait > 0) begin
				sink_wait--;
				out_ready <= 1'b0;
			end else if (sink_idle != 0 && $urandom_range(sink_idle - 1, 0) == 0) begin
				sink_wait = $urandom_range(15, 1) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) stall_count = 0;
			else stall_count++;
			if (stall_count >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, stall_count);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] u3, u7, u10;
		logic [15:0] unit_v;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part at the reset unit length, timestamps straddle the wrap
		u3  = 32'd3 * unit_len;
		u7  = 32'd7 * unit_len;
		u10 = 32'd10 * unit_len;
		stamp_ms = 32'hFFFF_FE00;
		push_poll(KEY_SPARE, 32'd0);
		push_poll(KEY_NONE, 32'hFFFF_FFFF);
		push_poll(KEY_RELEASE, stamp_ms);
		key_symbol(u7 + 32'd1);
		key_symbol(u7);
		key_gap(u7);
		key_symbol(u3 - 32'd1);
		push_poll(KEY_RELEASE, gap_ms + u10);
		key_end(u10 + 32'd1);
		key_symbol(u3);
		key_gap(u3 - 32'd1);
		key_symbol(32'd0);
		key_gap(u7 - 32'd1);
		key_symbol(32'd0);
		key_end(u10 + 32'd1);

		// random part, one unit length per phase
		stamp_ms = $urandom;
		for (int p = 0; p < PHASES; p++) begin
			case (p)
			0: unit_v = 16'd1;
			1: unit_v = 16'hFFFF;
			2: unit_v = 16'd0;
			3: unit_v = 16'd2;
			4: unit_v = 16'($urandom_range(65535, 1));
			5: unit_v = 16'($urandom_range(40, 3));
			6: unit_v = 16'($urandom_range(1000, 100));
			default: unit_v = UNIT_MS_RESET;
			endcase
			write_unit(unit_v);
			if (p == PHASES - 1) begin
				src_idle  = 0;
				sink_idle = 0;
			end else begin
				src_idle  = (p % 3 == 2) ? 0 : ((p % 2 == 1) ? 4 : 12);
				sink_idle = (p % 4 == 3) ? 0 : ((p % 2 == 0) ? 3 : 10);
			end
			if (p == 1 || p == 5) hold_req++;
			while (n_queued < (p + 1) * PHASE_POLLS) begin
				if ($urandom_range(9, 0) == 0) key_junk();
				else key_message();
			end
		end

		wait_settled();
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("sent %0d key polls over %0d unit lengths, checked %0d results", n_queued, n_units,
			n_results);
		$display("characters %0d, spaces %0d, message ends %0d, errors long/overflow/unknown %0d/%0d/%0d",
			n_kind[KIND_CHAR], n_kind[KIND_SPACE], n_kind[KIND_END], n_err[ERR_LONG],
			n_err[ERR_OVERFLOW], n_err[ERR_UNKNOWN]);
		if (n_fail == 0 && expected_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
